// ===== design/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, s-box and round helpers for the aes-128 pipeline
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned BlockBits = 128;
    localparam int unsigned HalfBits  = 64;
    localparam int unsigned IdxBits   = 1;

    localparam logic [IdxBits-1:0] RegKeyHigh = 1'b0;
    localparam logic [IdxBits-1:0] RegKeyLow  = 1'b1;

    typedef logic [BlockBits-1:0] t_block;

    localparam logic [7:0] Sbox [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte i sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(t_block b, int unsigned i);
        return b[BlockBits-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block sub_shift(t_block s);
        t_block t;
        t = '0;
        for (int unsigned c = 0; c < 4; c++) begin
            for (int unsigned r = 0; r < 4; r++) begin
                t[BlockBits-1-8*(r+4*c) -: 8] = Sbox[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        return t;
    endfunction

    function automatic t_block mix(t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int unsigned c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BlockBits-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic t_block next_key(t_block k, logic [7:0] rc);
        t_block n;
        logic [31:0] t, w;
        t = {Sbox[get_byte(k, 13)] ^ rc, Sbox[get_byte(k, 14)],
             Sbox[get_byte(k, 15)], Sbox[get_byte(k, 12)]};
        for (int unsigned i = 0; i < 4; i++) begin
            w = k[BlockBits-1-32*i -: 32] ^ t;
            n[BlockBits-1-32*i -: 32] = w;
            t = w;
        end
        return n;
    endfunction

endpackage

// ===== design/aes_stream_if.sv =====
// ----------------------------------------------------------------------------
// aes_stream_if
// valid/ready channel carrying one 128-bit block as two 64-bit halves
// ----------------------------------------------------------------------------
interface aes_stream_if;
    logic                           valid;
    logic                           ready;
    logic [aes_pkg::HalfBits-1:0]   data_high;
    logic [aes_pkg::HalfBits-1:0]   data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

// ===== design/aes_round_cell.sv =====
// ----------------------------------------------------------------------------
// aes_round_cell
// one pipeline cell: a cipher round and the matching key expansion step
// ----------------------------------------------------------------------------
module aes_round_cell #(
    parameter bit FinalRound = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [7:0]      i_rcon,
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_key,
    output logic            o_valid,
    output logic [7:0]      o_rcon,
    output aes_pkg::t_block o_state,
    output aes_pkg::t_block o_key
);
    aes_pkg::t_block n_key, n_state, w_sub;
    logic            r_valid;
    logic [7:0]      r_rcon;
    aes_pkg::t_block r_state, r_key;

    always_comb begin
        n_key = aes_pkg::next_key(i_key, i_rcon);
        w_sub = aes_pkg::sub_shift(i_state);
        if (FinalRound) begin
            n_state = w_sub ^ n_key;
        end else begin
            n_state = aes_pkg::mix(w_sub) ^ n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
            r_rcon  <= aes_pkg::xtime(i_rcon);
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
    assign o_rcon  = r_rcon;
endmodule

// ===== design/aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// aes-128 encryption as a row of ten round cells
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  s_in      in   valid/ready     plaintext_high, plaintext_low
//  m_out     out  valid/ready     ciphertext_high, ciphertext_low
//  config    in   i_cfg_we        i_cfg_index, i_cfg_data
//
//  one request per cycle while the output is not stalled; each request passes through every round cell in turn
//  the whole row advances together and holds while the output is stalled
//  a free last stage lets the row move even when the output waits
//  reset clears the key registers and all stage valid bits
module aes128_block_encrypt #(
    parameter int unsigned Rounds = aes_pkg::NumRounds
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [aes_pkg::IdxBits-1:0]   i_cfg_index,
    input  logic [aes_pkg::HalfBits-1:0]  i_cfg_data,
    aes_stream_if.sink                    s_in,
    aes_stream_if.source                  m_out
);
    logic [aes_pkg::HalfBits-1:0] r_key_high, r_key_low;
    logic                         w_en;

    logic            w_valid [Rounds+1];
    logic [7:0]      w_rcon  [Rounds+1];
    aes_pkg::t_block w_state [Rounds+1];
    aes_pkg::t_block w_key   [Rounds+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                aes_pkg::RegKeyHigh: r_key_high <= i_cfg_data;
                aes_pkg::RegKeyLow:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en       = m_out.ready || !w_valid[Rounds];
    assign s_in.ready = w_en;

    assign w_valid[0] = s_in.valid;
    assign w_rcon[0]  = 8'h01;
    assign w_key[0]   = {r_key_high, r_key_low};
    assign w_state[0] = {s_in.data_high, s_in.data_low} ^ {r_key_high, r_key_low};

    for (genvar g = 0; g < Rounds; g++) begin : g_cell
        aes_round_cell #(
            .FinalRound(g == Rounds - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_rcon  (w_rcon[g]),
            .i_state (w_state[g]),
            .i_key   (w_key[g]),
            .o_valid (w_valid[g+1]),
            .o_rcon  (w_rcon[g+1]),
            .o_state (w_state[g+1]),
            .o_key   (w_key[g+1])
        );
    end

    assign m_out.valid     = w_valid[Rounds];
    assign m_out.data_high = w_state[Rounds][aes_pkg::BlockBits-1 -: aes_pkg::HalfBits];
    assign m_out.data_low  = w_state[Rounds][aes_pkg::HalfBits-1:0];
endmodule

// ===== tb/sv/aes128_block_encrypt_tb.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt_tb
// drives plaintext blocks under several keys through the encryption pipeline
// and checks every ciphertext against a predictor in the testbench. the
// sender runs in random bursts, the receiver stalls on its own pattern and
// once holds off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned StallLimit = 3000;
    localparam int unsigned DrainCycles = 20;
    localparam int unsigned RandomItems = 800;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } t_cipher;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [aes_pkg::IdxBits-1:0] i_cfg_index;
    logic [aes_pkg::HalfBits-1:0] i_cfg_data;

    aes_stream_if plain_if ();
    aes_stream_if cipher_if ();

    aes128_block_encrypt dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_in        (plain_if),
        .m_out       (cipher_if)
    );

    logic [7:0] sub_table [256];
    logic [63:0] key_high_q;
    logic [63:0] key_low_q;
    t_cipher pending_cipher [$];
    int unsigned mismatches;
    int unsigned burst_left;
    bit gaps_off;
    bit hold_req;
    int unsigned hold_len;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // s-box from the field inverse (a^254) and the affine map
    task automatic build_sub_table();
        logic [7:0] inv, b;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h01;
            for (int e = 0; e < 254; e++) inv = gf_mul(inv, v[7:0]);
            if (v == 0) inv = 8'h00;
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_table[v] = b;
        end
    endtask

    function automatic logic [7:0] dbl(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_cipher encrypt_block(logic [127:0] key, logic [127:0] text);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] t0, t1, t2, t3, u, rc, all;
        t_cipher res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127-8*i -: 8];
            st[i] = text[127-8*i -: 8] ^ rk[i];
        end
        for (int i = 16; i < 176; i += 4) begin
            t0 = rk[i-4]; t1 = rk[i-3]; t2 = rk[i-2]; t3 = rk[i-1];
            if (i % 16 == 0) begin
                u = t0;
                t0 = sub_table[t1] ^ rc;
                t1 = sub_table[t2];
                t2 = sub_table[t3];
                t3 = sub_table[u];
                rc = dbl(rc);
            end
            rk[i] = rk[i-16] ^ t0;
            rk[i+1] = rk[i-15] ^ t1;
            rk[i+2] = rk[i-14] ^ t2;
            rk[i+3] = rk[i-13] ^ t3;
        end
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    tmp[w+4*c] = sub_table[st[w+4*((c+w)%4)]];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    all = tmp[4*c] ^ tmp[4*c+1] ^ tmp[4*c+2] ^ tmp[4*c+3];
                    st[4*c] = tmp[4*c] ^ all ^ dbl(tmp[4*c] ^ tmp[4*c+1]);
                    st[4*c+1] = tmp[4*c+1] ^ all ^ dbl(tmp[4*c+1] ^ tmp[4*c+2]);
                    st[4*c+2] = tmp[4*c+2] ^ all ^ dbl(tmp[4*c+2] ^ tmp[4*c+3]);
                    st[4*c+3] = tmp[4*c+3] ^ all ^ dbl(tmp[4*c+3] ^ tmp[4*c]);
                end
            end else begin
                for (int i = 0; i < 16; i++) st[i] = tmp[i];
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[16*r+i];
        end
        for (int i = 0; i < 8; i++) begin
            res.high[63-8*i -: 8] = st[i];
            res.low[63-8*i -: 8] = st[i+8];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_block(logic [63:0] hi, logic [63:0] lo);
        if (!gaps_off && burst_left == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                plain_if.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        plain_if.valid = 1'b1;
        plain_if.data_high = hi;
        plain_if.data_low = lo;
        do @(posedge i_clk); while (!plain_if.ready);
        pending_cipher.push_back(encrypt_block({key_high_q, key_low_q}, {hi, lo}));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        plain_if.valid = 1'b0;
        while (pending_cipher.size() != 0) @(posedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [aes_pkg::IdxBits-1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == aes_pkg::RegKeyHigh) key_high_q = value;
        else key_low_q = value;
    endtask

    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        wait_idle();
        write_reg(aes_pkg::RegKeyHigh, hi);
        write_reg(aes_pkg::RegKeyLow, lo);
    endtask

    task automatic test_reset_key();
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h8000_0000_0000_0000, 64'h1);
    endtask

    task automatic test_standard_vector();
        load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        load_key(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c);
        send_block(64'h3243_f6a8_885a_308d, 64'h3131_98a2_e037_0734);
    endtask

    task automatic test_key_extremes();
        load_key('1, '1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        load_key(64'h0, '1);
        send_block(64'h0, '1);
        send_block('1, 64'h0);
        load_key('1, 64'h0);
        send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    endtask

    task automatic test_random_blocks();
        for (int p = 0; p < 8; p++) begin
            load_key(rand64(), rand64());
            for (int n = 0; n < RandomItems / 8; n++) begin
                case ($urandom_range(0, 9))
                    0: send_block('1, rand64());
                    1: send_block(rand64(), 64'h0);
                    default: send_block(rand64(), rand64());
                endcase
            end
        end
    endtask

    task automatic test_backpressure();
        load_key(rand64(), rand64());
        gaps_off = 1'b1;
        hold_len = 300;
        hold_req = 1'b1;
        repeat (40) send_block(rand64(), rand64());
        gaps_off = 1'b0;
    endtask

    // receiver: pattern of its own, plus a counted hold-off on request
    initial begin
        int unsigned mode;
        int unsigned left;
        int unsigned held;
        cipher_if.ready = 1'b0;
        mode = 0;
        left = 0;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 80);
            end
            left--;
            if (hold_req) begin
                cipher_if.ready = 1'b0;
                held++;
                if (held >= hold_len) begin
                    hold_req = 1'b0;
                    held = 0;
                end
            end else begin
                case (mode)
                    0: cipher_if.ready = 1'b1;
                    1: cipher_if.ready = ($urandom_range(0, 1) == 1);
                    2: cipher_if.ready = ($urandom_range(0, 3) == 0);
                    default: cipher_if.ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        t_cipher want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && cipher_if.valid && cipher_if.ready) begin
                if (pending_cipher.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected ciphertext %h %h",
                                 cipher_if.data_high, cipher_if.data_low);
                end else begin
                    want = pending_cipher.pop_front();
                    if (cipher_if.data_high !== want.high
                        || cipher_if.data_low !== want.low) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ciphertext mismatch: expected %h %h, got %h %h",
                                     want.high, want.low,
                                     cipher_if.data_high, cipher_if.data_low);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((plain_if.valid && plain_if.ready) || (cipher_if.valid && cipher_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= StallLimit) begin
                $display("aes128_block_encrypt_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = aes_pkg::RegKeyHigh;
        i_cfg_data = '0;
        plain_if.valid = 1'b0;
        plain_if.data_high = '0;
        plain_if.data_low = '0;
        key_high_q = '0;
        key_low_q = '0;
        mismatches = 0;
        burst_left = 0;
        gaps_off = 1'b0;
        hold_req = 1'b0;
        hold_len = 0;
        build_sub_table();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_standard_vector();
        test_key_extremes();
        test_random_blocks();
        test_backpressure();

        wait_idle();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0 && pending_cipher.size() == 0)
            $display("aes128_block_encrypt_tb: PASS");
        else
            $display("aes128_block_encrypt_tb: FAIL");
        $finish;
    end
endmodule
